// ===== design/ensemble_sort_missing_last_assert.svh =====
// Assertion macros used by the checker file of the ensemble sort block.
`ifndef ENSEMBLE_SORT_MISSING_LAST_ASSERT_SVH
`define ENSEMBLE_SORT_MISSING_LAST_ASSERT_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define ESML_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled during reset.
`define ESML_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/esml_pkg.sv =====
// Package with the entry type, sizes and ordering function of the ensemble sort block.
package esml_pkg;

    localparam int MAX_MEMBERS = 32;
    localparam int VALUE_W     = 32;

    typedef struct packed {
        logic               occ;
        logic               valid;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } cell_ctrl_t;

    function automatic logic goes_after(entry_t a, entry_t b);
        logic res;
        if (!b.valid) begin
            res = 1'b0;
        end else if (!a.valid) begin
            res = 1'b1;
        end else begin
            res = ($signed(a.value) >= $signed(b.value));
        end
        return res;
    endfunction

endpackage

// ===== design/esml_cell.sv =====
// One cell of the insertion chain: holds one stored member and shifts it on demand.
module esml_cell
    import esml_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_ent,
    input  entry_t     left_ent,
    input  logic       left_cond,
    input  entry_t     right_ent,
    output entry_t     cur_ent,
    output logic       cond
);

    entry_t entry_reg;
    entry_t entry_next;

    // The new member belongs at or before this cell.
    assign cond = !entry_reg.occ || !goes_after(new_ent, entry_reg);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.shift_out) begin
            entry_next = right_ent;
        end else if (ctrl.insert && cond) begin
            entry_next = left_cond ? left_ent : new_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.occ <= 1'b0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign cur_ent = entry_reg;

endmodule

// ===== design/ensemble_sort_missing_last.sv =====
// One input word is taken per cycle while a group fills the chain of cells.
// After the word with tlast, the block enters its drain state and results are registered
// out one per cycle while m_tready stays high; the chain drains through cell zero.
// Input is stalled from the tlast word until the last result has left the chain.
// Reset (aresetn low, synchronous) empties every cell, clears the overflow flag and
// the output valid.
module ensemble_sort_missing_last
    import esml_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] member_value
    input  logic [0:0]  s_tuser,  // [0] member_valid
    input  logic        s_tlast,  // group_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [31:0] sorted_value
    output logic [1:0]  m_tuser,  // [0] sorted_valid, [1] overflow
    output logic        m_tlast   // run_last
);

    typedef enum logic {ST_FILL, ST_DRAIN} state_t;

    state_t             state_reg;
    logic               ovf_reg;
    logic               m_valid_reg;
    logic [VALUE_W-1:0] m_value_reg;
    logic               m_svalid_reg;
    logic               m_last_reg;
    logic               m_ovf_reg;

    entry_t     cell_ent   [MAX_MEMBERS];
    logic       cell_cond  [MAX_MEMBERS];
    entry_t     left_ent   [MAX_MEMBERS];
    logic       left_cond  [MAX_MEMBERS];
    entry_t     right_ent  [MAX_MEMBERS];
    entry_t     new_ent;
    cell_ctrl_t ctrl;

    logic s_accept;
    logic full;
    logic load_out;

    assign s_tready = (state_reg == ST_FILL);
    assign s_accept = s_tvalid && s_tready;
    assign full     = cell_ent[MAX_MEMBERS-1].occ;
    assign load_out = (state_reg == ST_DRAIN) && cell_ent[0].occ
                      && (!m_valid_reg || m_tready);

    assign new_ent.occ   = 1'b1;
    assign new_ent.valid = s_tuser[0];
    assign new_ent.value = s_tuser[0] ? s_tdata : '0;

    assign ctrl.insert    = s_accept && !full;
    assign ctrl.shift_out = load_out;

    always_comb begin
        for (int i = 0; i < MAX_MEMBERS; i++) begin
            if (i == 0) begin
                left_ent[i]  = new_ent;
                left_cond[i] = 1'b0;
            end else begin
                left_ent[i]  = cell_ent[i-1];
                left_cond[i] = cell_cond[i-1];
            end
            if (i == MAX_MEMBERS - 1) begin
                right_ent[i] = '0;
            end else begin
                right_ent[i] = cell_ent[i+1];
            end
        end
    end

    for (genvar g = 0; g < MAX_MEMBERS; g++) begin : g_cell
        esml_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .new_ent   (new_ent),
            .left_ent  (left_ent[g]),
            .left_cond (left_cond[g]),
            .right_ent (right_ent[g]),
            .cur_ent   (cell_ent[g]),
            .cond      (cell_cond[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_FILL;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_FILL: begin
                    if (s_accept) begin
                        if (full) begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (!cell_ent[0].occ) begin
                        state_reg <= ST_FILL;
                        ovf_reg   <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= ST_FILL;
                end
            endcase
            if (load_out) begin
                m_valid_reg  <= 1'b1;
                m_value_reg  <= cell_ent[0].value;
                m_svalid_reg <= cell_ent[0].valid;
                m_last_reg   <= !cell_ent[1].occ;
                m_ovf_reg    <= ovf_reg;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = {m_ovf_reg, m_svalid_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ===== design/esml_checker.sv =====
// Port-level checker for the ensemble sort block and its bind to the top level.
`include "ensemble_sort_missing_last_assert.svh"

module esml_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A word with tlast starts draining, so the input side stalls on the next cycle.
    `ESML_ASSERT_NEXT(a_stall_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "input accepted right after a group end")

    // A missing member always carries a zero value.
    `ESML_ASSERT_NOW(a_missing_zero, m_tvalid && !m_tuser[0], m_tdata == 32'd0, "missing member with nonzero value")

    // Within a group, the word right after a taken missing member is not a valid member.
    `ESML_ASSERT_NEXT(a_missing_last, m_tvalid && m_tready && !m_tuser[0] && !m_tlast, !(m_tvalid && m_tuser[0]), "valid member after a missing one")

    // A stalled result word holds its data.
    `ESML_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result word changed")

endmodule

bind ensemble_sort_missing_last esml_checker u_esml_checker (.*);
